>>> hw/rtl/json_token_lexer_macros.svh
// Assertion macros shared by the lexer RTL.
`ifndef JSON_TOKEN_LEXER_MACROS_SVH
`define JSON_TOKEN_LEXER_MACROS_SVH
`ifndef SYNTHESIS
`define JTL_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define JTL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define JTL_ASSERT(lbl, clk, rst, prop, msg)
`define JTL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> hw/rtl/jtl_pkg.sv
package jtl_pkg;

  typedef enum logic [3:0] {
    M_IDLE = 4'd0,
    M_STR  = 4'd1,
    M_ESC  = 4'd2,
    M_NUM  = 4'd3,
    M_EXPS = 4'd4,
    M_EXPD = 4'd5,
    M_KW   = 4'd6
  } mode_t;

  localparam logic [3:0] TK_LBRACE = 4'd0;
  localparam logic [3:0] TK_RBRACE = 4'd1;
  localparam logic [3:0] TK_LBRACK = 4'd2;
  localparam logic [3:0] TK_RBRACK = 4'd3;
  localparam logic [3:0] TK_COLON  = 4'd4;
  localparam logic [3:0] TK_COMMA  = 4'd5;
  localparam logic [3:0] TK_STRING = 4'd6;
  localparam logic [3:0] TK_INT    = 4'd7;
  localparam logic [3:0] TK_FLOAT  = 4'd8;
  localparam logic [3:0] TK_BOOL   = 4'd9;
  localparam logic [3:0] TK_NULL   = 4'd10;
  localparam logic [3:0] TK_EOF    = 4'd11;
  localparam logic [3:0] TK_ERROR  = 4'd12;
  localparam logic [3:0] TK_NONE   = 4'd0;

  localparam logic [1:0] KW_TRUE  = 2'd0;
  localparam logic [1:0] KW_FALSE = 2'd1;
  localparam logic [1:0] KW_NULL  = 2'd2;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;

  localparam int unsigned SHOWN_WIDTH = 16;

  typedef struct packed {
    logic       has_char;
    logic [7:0] char_value;
    logic       token_end;
    logic [3:0] token_kind;
  } result_t;

  typedef struct packed {
    result_t                 res;
    logic [SHOWN_WIDTH-1:0]  errors;
    logic                    last;
  } entry_t;

  typedef struct packed {
    mode_t      mode;
    logic       emit;
    result_t    res;
    logic       kw_start;
    logic [1:0] kw_sel;
    logic       num_start;
  } idle_t;

  typedef struct packed {
    logic       bad;
    logic [7:0] value;
  } esc_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic result_t mk_res(input logic has, input logic [7:0] ch,
                                     input logic fin, input logic [3:0] kind);
    result_t r;
    r.has_char   = has;
    r.char_value = ch;
    r.token_end  = fin;
    r.token_kind = kind;
    return r;
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] sel, input logic [2:0] pos);
    logic [7:0] ch;
    ch = CH_NUL;
    case ({sel, pos})
      {KW_TRUE, 3'd0}:  ch = "t";
      {KW_TRUE, 3'd1}:  ch = "r";
      {KW_TRUE, 3'd2}:  ch = "u";
      {KW_TRUE, 3'd3}:  ch = "e";
      {KW_FALSE, 3'd0}: ch = "f";
      {KW_FALSE, 3'd1}: ch = "a";
      {KW_FALSE, 3'd2}: ch = "l";
      {KW_FALSE, 3'd3}: ch = "s";
      {KW_FALSE, 3'd4}: ch = "e";
      {KW_NULL, 3'd0}:  ch = "n";
      {KW_NULL, 3'd1}:  ch = "u";
      {KW_NULL, 3'd2}:  ch = "l";
      {KW_NULL, 3'd3}:  ch = "l";
      default:          ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] sel);
    return (sel == KW_FALSE) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic [3:0] kw_kind(input logic [1:0] sel);
    return (sel == KW_NULL) ? TK_NULL : TK_BOOL;
  endfunction

  function automatic esc_t esc_decode(input logic [7:0] c);
    esc_t e;
    e.bad   = 1'b0;
    e.value = c;
    case (c) inside
      CH_QUOTE, CH_BSLASH, 8'h2F: e.value = c;
      "b":     e.value = 8'h08;
      "f":     e.value = 8'h0C;
      "n":     e.value = 8'h0A;
      "r":     e.value = 8'h0D;
      "t":     e.value = 8'h09;
      default: e.bad   = 1'b1;
    endcase
    return e;
  endfunction

  // What a byte does when it is seen between tokens.
  function automatic idle_t idle_decode(input logic [7:0] c);
    idle_t d;
    d.mode      = M_IDLE;
    d.emit      = 1'b0;
    d.res       = mk_res(1'b1, c, 1'b1, TK_NONE);
    d.kw_start  = 1'b0;
    d.kw_sel    = KW_TRUE;
    d.num_start = 1'b0;
    case (c) inside
      8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: d.emit = 1'b0;
      "{": begin d.emit = 1'b1; d.res.token_kind = TK_LBRACE; end
      "}": begin d.emit = 1'b1; d.res.token_kind = TK_RBRACE; end
      "[": begin d.emit = 1'b1; d.res.token_kind = TK_LBRACK; end
      "]": begin d.emit = 1'b1; d.res.token_kind = TK_RBRACK; end
      ":": begin d.emit = 1'b1; d.res.token_kind = TK_COLON; end
      ",": begin d.emit = 1'b1; d.res.token_kind = TK_COMMA; end
      CH_QUOTE: d.mode = M_STR;
      "t", "f", "n": begin
        d.mode     = M_KW;
        d.kw_start = 1'b1;
        d.kw_sel   = (c == "t") ? KW_TRUE : ((c == "f") ? KW_FALSE : KW_NULL);
        d.emit     = 1'b1;
        d.res      = mk_res(1'b1, c, 1'b0, TK_NONE);
      end
      CH_NUL: begin
        d.emit = 1'b1;
        d.res  = mk_res(1'b0, CH_NUL, 1'b1, TK_EOF);
      end
      default: begin
        d.emit = 1'b1;
        if (is_digit(c) || (c == CH_MINUS)) begin
          d.mode      = M_NUM;
          d.num_start = 1'b1;
          d.res       = mk_res(1'b1, c, 1'b0, TK_NONE);
        end else begin
          d.res = mk_res(1'b0, c, 1'b1, TK_ERROR);
        end
      end
    endcase
    return d;
  endfunction

endpackage

>>> hw/rtl/jtl_lex.sv
`include "json_token_lexer_macros.svh"

module jtl_lex import jtl_pkg::*; #(
  parameter int ERROR_COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [7:0]             in_byte,
  output logic                   res0_valid,
  output result_t                res0,
  output logic                   res1_valid,
  output result_t                res1,
  output logic [SHOWN_WIDTH-1:0] errors_seen
);

  mode_t                        mode, mode_next;
  logic [2:0]                   kw_pos, kw_pos_next;
  logic [1:0]                   kw_sel, kw_sel_next;
  logic                         seen_dot, seen_dot_next;
  logic                         float_seen, float_seen_next;
  logic [ERROR_COUNT_WIDTH-1:0] tally, tally_next;

  idle_t      idle;
  esc_t       esc;
  logic [1:0] sel;
  logic [2:0] pos_inc;
  logic       kw_match;
  logic       kw_last;
  logic       num_end;
  logic       relex;
  logic       err;
  logic [ERROR_COUNT_WIDTH+SHOWN_WIDTH-1:0] tally_wide;

  // Shared decode of the byte against the current mode.
  always_comb begin
    idle     = idle_decode(in_byte);
    esc      = esc_decode(in_byte);
    sel      = (kw_sel == 2'd3) ? KW_TRUE : kw_sel;
    pos_inc  = kw_pos + 3'd1;
    kw_match = (kw_pos < kw_len(sel)) && (in_byte == kw_char(sel, kw_pos));
    kw_last  = pos_inc >= kw_len(sel);
    num_end  = 1'b0;
    relex    = 1'b0;
    case (mode) inside
      M_NUM: begin
        num_end = !(is_digit(in_byte) || ((in_byte == CH_DOT) && !seen_dot) ||
                    (in_byte == CH_LOW_E) || (in_byte == CH_UP_E));
        relex   = num_end;
      end
      M_EXPS: begin
        num_end = !(is_digit(in_byte) || (in_byte == CH_PLUS) || (in_byte == CH_MINUS));
        relex   = num_end;
      end
      M_EXPD: begin
        num_end = !is_digit(in_byte);
        relex   = num_end;
      end
      M_STR, M_ESC, M_KW: relex = 1'b0;
      default: relex = 1'b1;
    endcase
  end

  // Next state.
  always_comb begin
    mode_next       = mode;
    kw_pos_next     = kw_pos;
    kw_sel_next     = kw_sel;
    seen_dot_next   = seen_dot;
    float_seen_next = float_seen;
    err             = 1'b0;
    unique case (mode)
      M_STR: begin
        if ((in_byte == CH_QUOTE) || (in_byte == CH_NUL)) begin
          mode_next = M_IDLE;
        end else if (in_byte == CH_BSLASH) begin
          mode_next = M_ESC;
        end
      end
      M_ESC: begin
        mode_next = esc.bad ? M_IDLE : M_STR;
        err       = esc.bad;
      end
      M_NUM: begin
        if (in_byte == CH_DOT && !seen_dot) begin
          seen_dot_next   = 1'b1;
          float_seen_next = 1'b1;
        end else if ((in_byte == CH_LOW_E) || (in_byte == CH_UP_E)) begin
          float_seen_next = 1'b1;
          mode_next       = M_EXPS;
        end
      end
      M_EXPS: begin
        if (!num_end) begin
          mode_next = M_EXPD;
        end
      end
      M_EXPD: mode_next = mode;
      M_KW: begin
        if (kw_match) begin
          kw_pos_next = pos_inc;
          if (kw_last) begin
            mode_next = M_IDLE;
          end
        end else begin
          err       = 1'b1;
          mode_next = M_IDLE;
        end
      end
      default: mode_next = M_IDLE;
    endcase
    if (relex) begin
      mode_next = idle.mode;
      if (idle.kw_start) begin
        kw_sel_next = idle.kw_sel;
        kw_pos_next = 3'd1;
      end
      if (idle.num_start) begin
        seen_dot_next   = 1'b0;
        float_seen_next = 1'b0;
      end
    end
    tally_next = tally;
    if (err && (tally != {ERROR_COUNT_WIDTH{1'b1}})) begin
      tally_next = tally + ERROR_COUNT_WIDTH'(1);
    end
  end

  // Result items.
  always_comb begin
    res0_valid = 1'b0;
    res1_valid = 1'b0;
    res0       = mk_res(1'b1, in_byte, 1'b0, TK_NONE);
    res1       = mk_res(1'b0, CH_NUL, 1'b1, TK_EOF);
    unique case (mode) inside
      M_STR: begin
        if (in_byte == CH_QUOTE) begin
          res0_valid = 1'b1;
          res0       = mk_res(1'b0, CH_NUL, 1'b1, TK_STRING);
        end else if (in_byte == CH_NUL) begin
          res0_valid = 1'b1;
          res0       = mk_res(1'b0, CH_NUL, 1'b1, TK_STRING);
          res1_valid = 1'b1;
        end else if (in_byte != CH_BSLASH) begin
          res0_valid = 1'b1;
        end
      end
      M_ESC: begin
        res0_valid = 1'b1;
        if (!esc.bad) begin
          res0 = mk_res(1'b1, esc.value, 1'b0, TK_NONE);
        end else begin
          res0       = mk_res(1'b0, in_byte, 1'b1, TK_ERROR);
          res1_valid = (in_byte == CH_NUL);
        end
      end
      M_NUM, M_EXPS, M_EXPD: begin
        res0_valid = 1'b1;
        if (num_end) begin
          res0       = mk_res(1'b0, CH_NUL, 1'b1, float_seen ? TK_FLOAT : TK_INT);
          res1_valid = idle.emit;
          res1       = idle.res;
        end
      end
      M_KW: begin
        res0_valid = 1'b1;
        if (kw_match) begin
          res0 = mk_res(1'b1, in_byte, kw_last, kw_last ? kw_kind(sel) : TK_NONE);
        end else begin
          res0       = mk_res(1'b0, in_byte, 1'b1, TK_ERROR);
          res1_valid = (in_byte == CH_NUL);
        end
      end
      default: begin
        res0_valid = idle.emit;
        res0       = idle.res;
      end
    endcase
  end

  // The tally shown with each result saturates at the port width.
  always_comb begin
    tally_wide = {{SHOWN_WIDTH{1'b0}}, tally_next};
    if (tally_wide > (ERROR_COUNT_WIDTH+SHOWN_WIDTH)'({SHOWN_WIDTH{1'b1}})) begin
      errors_seen = {SHOWN_WIDTH{1'b1}};
    end else begin
      errors_seen = tally_wide[SHOWN_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_IDLE;
      kw_pos     <= 3'd0;
      kw_sel     <= KW_TRUE;
      seen_dot   <= 1'b0;
      float_seen <= 1'b0;
      tally      <= '0;
    end else if (step) begin
      mode       <= mode_next;
      kw_pos     <= kw_pos_next;
      kw_sel     <= kw_sel_next;
      seen_dot   <= seen_dot_next;
      float_seen <= float_seen_next;
      tally      <= tally_next;
    end
  end

  `JTL_ASSERT(a_lex_order, clk, rst, res0_valid || !res1_valid, "second result without first")
  `JTL_ASSERT_NEXT(a_lex_tally, clk, rst, step, tally >= $past(tally), "error tally went down")
  `JTL_ASSERT_NEXT(a_lex_hold, clk, rst, !step, mode == $past(mode), "mode moved without a byte")

endmodule

>>> hw/rtl/jtl_outq.sv
`include "json_token_lexer_macros.svh"

module jtl_outq import jtl_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push0,
  input  entry_t entry0,
  input  logic   push1,
  input  entry_t entry1,
  output logic   room2,
  output logic   head_valid,
  output entry_t head,
  input  logic   pop_stall
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PW    = $clog2(DEPTH);

  entry_t        mem [DEPTH];
  logic [PW-1:0] wr_ptr, wr_ptr_next;
  logic [PW-1:0] rd_ptr, rd_ptr_next;
  logic [PW:0]   count, count_next;
  logic          pop;
  logic [PW-1:0] wr_ptr_b;

  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign pop        = head_valid && !pop_stall;
  assign room2      = (count <= (PW+1)'(DEPTH - 2));
  assign wr_ptr_b   = wr_ptr + 1'b1;

  always_comb begin
    wr_ptr_next = wr_ptr + PW'({1'b0, push0} + {1'b0, push1});
    rd_ptr_next = rd_ptr + PW'(pop);
    count_next  = count + (PW+1)'(push0) + (PW+1)'(push1) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      mem[wr_ptr] <= entry0;
    end
    if (push1) begin
      mem[wr_ptr_b] <= entry1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  `JTL_ASSERT(a_q_room, clk, rst, !(push0 && !room2), "push into a queue without room")
  `JTL_ASSERT(a_q_pair, clk, rst, push0 || !push1, "second entry pushed alone")
  `JTL_ASSERT(a_q_count, clk, rst, count <= (PW+1)'(DEPTH), "queue count overflow")

endmodule

>>> hw/rtl/json_token_lexer.sv
// Streaming JSON lexer: one text byte in per transfer, token text out one
// character per transfer.
// The input channel (byte_valid, byte_stall, in_byte) takes one byte of JSON
// text per transfer; a zero byte marks the end of the input and yields an eof
// token. The result channel (res_valid, res_stall and the result fields)
// carries one item per transfer: a text character, a token end with its kind,
// or both. Every byte yields zero, one or two items; last_in_run marks the
// final item of a byte, and errors_seen shows the saturated error tally.
// An accepted byte waits in the input register and is lexed there; its
// items are written into the result queue, whose head is offered on the
// result channel. A byte is taken every cycle while the result queue has
// room for two items; the output drains one item per cycle while
// res_stall is low, so the byte rate follows the item rate, and a byte
// that closes a number and opens another token yields two items.
// When the receiver stalls, the four-entry result queue fills; once it holds
// three or more items a waiting byte is not lexed and byte_stall rises. No
// item is lost or repeated. Reset clears the lexer to the state between
// tokens, zeroes the error tally and empties the queue.
// No item is offered before the first byte after reset.
module json_token_lexer import jtl_pkg::*; #(
  parameter int ERROR_COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_stall,
  input  logic [7:0]             in_byte,
  output logic                   res_valid,
  input  logic                   res_stall,
  output logic                   has_char,
  output logic [7:0]             char_value,
  output logic                   token_end,
  output logic [3:0]             token_kind,
  output logic [SHOWN_WIDTH-1:0] errors_seen,
  output logic                   last_in_run
);

  // Input register: holds one byte until the lexer can retire it.
  logic       iv;
  logic [7:0] ib;
  logic       iv_next;
  logic       accept;
  logic       step;
  logic       room2;

  logic                   res0_valid, res1_valid;
  result_t                res0, res1;
  logic [SHOWN_WIDTH-1:0] lex_errors;
  entry_t                 entry0, entry1, head;

  // A byte is lexed when the queue can take both of its possible items.
  assign step       = iv && room2;
  assign byte_stall = iv && !room2;
  assign accept     = byte_valid && !byte_stall;

  always_comb begin
    iv_next = iv;
    if (accept) begin
      iv_next = 1'b1;
    end else if (step) begin
      iv_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else begin
      iv <= iv_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ib <= in_byte;
    end
  end

  jtl_lex #(
    .ERROR_COUNT_WIDTH(ERROR_COUNT_WIDTH)
  ) u_lex (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .in_byte    (ib),
    .res0_valid (res0_valid),
    .res0       (res0),
    .res1_valid (res1_valid),
    .res1       (res1),
    .errors_seen(lex_errors)
  );

  // Both items of one byte carry the tally after that byte.
  always_comb begin
    entry0.res    = res0;
    entry0.errors = lex_errors;
    entry0.last   = !res1_valid;
    entry1.res    = res1;
    entry1.errors = lex_errors;
    entry1.last   = 1'b1;
  end

  jtl_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push0     (step && res0_valid),
    .entry0    (entry0),
    .push1     (step && res1_valid),
    .entry1    (entry1),
    .room2     (room2),
    .head_valid(res_valid),
    .head      (head),
    .pop_stall (res_stall)
  );

  assign has_char    = head.res.has_char;
  assign char_value  = head.res.char_value;
  assign token_end   = head.res.token_end;
  assign token_kind  = head.res.token_kind;
  assign errors_seen = head.errors;
  assign last_in_run = head.last;

  `JTL_ASSERT_NEXT(a_top_hold, clk, rst, byte_stall, iv && (ib == $past(ib)), "held byte lost")
  `JTL_ASSERT(a_top_stall, clk, rst, !(byte_stall && step), "stall while lexing a byte")
  `JTL_ASSERT_NEXT(a_top_step, clk, rst, step && !accept, !iv, "retired byte still pending")

endmodule
